// File: rtl/sdwm_pkg.sv
`timescale 1ns / 1ps
package sdwm_pkg;

    // Build defaults
    localparam int DEPTH_DEF       = 131072;
    localparam int SAMPLE_BITS_DEF = 24;

    // Register file
    localparam int CFG_W    = 17;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_DELAY = 3'd0;
    localparam logic [IDX_W-1:0] REG_BLEND = 3'd1;
    localparam logic [IDX_W-1:0] REG_WET   = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIX   = 3'd4;

    localparam logic [CFG_W-1:0] DELAY_RST = 17'd22050;
    localparam logic [CFG_W-1:0] BLEND_RST = 17'd32768;
    localparam logic [CFG_W-1:0] WET_RST   = 17'd19661;
    localparam logic [CFG_W-1:0] WIDTH_RST = 17'd32768;
    localparam logic [CFG_W-1:0] MIX_RST   = 17'd32768;

    // Unity gain in Q1.16
    localparam logic [CFG_W-1:0] GAIN_ONE = 17'h10000;

    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] blend;
        logic [CFG_W-1:0] wet;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] mix;
    } sdwm_cfg_t;

    // Hold conditions of a step
    localparam logic [1:0] H_NONE = 2'd0;
    localparam logic [1:0] H_IN   = 2'd1;
    localparam logic [1:0] H_MOD  = 2'd2;
    localparam logic [1:0] H_OUT  = 2'd3;

    // Delay store operations
    localparam logic [1:0] ST_NOP   = 2'd0;
    localparam logic [1:0] ST_MOD   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    // Multiplier A operand
    localparam logic [3:0] A_XL  = 4'd0;
    localparam logic [3:0] A_XR  = 4'd1;
    localparam logic [3:0] A_DL  = 4'd2;
    localparam logic [3:0] A_DR  = 4'd3;
    localparam logic [3:0] A_T0  = 4'd4;
    localparam logic [3:0] A_T1  = 4'd5;
    localparam logic [3:0] A_T2  = 4'd6;
    localparam logic [3:0] A_SUM = 4'd7;
    localparam logic [3:0] A_DIF = 4'd8;

    // Multiplier B operand (gains)
    localparam logic [2:0] B_R   = 3'd0;
    localparam logic [2:0] B_NR  = 3'd1;
    localparam logic [2:0] B_WG  = 3'd2;
    localparam logic [2:0] B_ONE = 3'd3;
    localparam logic [2:0] B_SW  = 3'd4;
    localparam logic [2:0] B_MG  = 3'd5;

    // Accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // Destination of the rounded accumulator
    localparam logic [2:0] R_NONE = 3'd0;
    localparam logic [2:0] R_T0   = 3'd1;
    localparam logic [2:0] R_T1   = 3'd2;
    localparam logic [2:0] R_T2   = 3'd3;
    localparam logic [2:0] R_OL   = 3'd4;
    localparam logic [2:0] R_OR   = 3'd5;

    // Program addresses
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] U_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] U_MODW  = 5'd1;
    localparam logic [STEP_W-1:0] U_WRITE = 5'd2;
    localparam logic [STEP_W-1:0] U_READ  = 5'd3;
    localparam logic [STEP_W-1:0] U_BLL0  = 5'd4;
    localparam logic [STEP_W-1:0] U_BLL1  = 5'd5;
    localparam logic [STEP_W-1:0] U_BLR0  = 5'd6;
    localparam logic [STEP_W-1:0] U_BLR1  = 5'd7;
    localparam logic [STEP_W-1:0] U_WGL   = 5'd8;
    localparam logic [STEP_W-1:0] U_WGR   = 5'd9;
    localparam logic [STEP_W-1:0] U_WGE   = 5'd10;
    localparam logic [STEP_W-1:0] U_MID0  = 5'd11;
    localparam logic [STEP_W-1:0] U_MID1  = 5'd12;
    localparam logic [STEP_W-1:0] U_SIDE0 = 5'd13;
    localparam logic [STEP_W-1:0] U_SIDE1 = 5'd14;
    localparam logic [STEP_W-1:0] U_MIXL  = 5'd15;
    localparam logic [STEP_W-1:0] U_MIXR  = 5'd16;
    localparam logic [STEP_W-1:0] U_MIXE  = 5'd17;
    localparam logic [STEP_W-1:0] U_EMIT  = 5'd18;

    typedef struct packed {
        logic              take;
        logic              emit;
        logic [1:0]        hold;
        logic              jmp;
        logic [STEP_W-1:0] target;
        logic [1:0]        st_op;
        logic [3:0]        a_sel;
        logic [2:0]        b_sel;
        logic [1:0]        acc_op;
        logic [2:0]        rnd_dst;
        logic              rnd17;
    } sdwm_uc_t;

    typedef struct packed {
        logic in_valid;
        logic mod_done;
        logic out_free;
    } sdwm_stat_t;

    // Control program: one word per step
    function automatic sdwm_uc_t ucode(input logic [STEP_W-1:0] step);
        sdwm_uc_t w;
        w = '0;
        unique case (step)
            U_IDLE:
            begin
                w.take  = 1'b1;
                w.hold  = H_IN;
                w.st_op = ST_MOD;
            end
            U_MODW:  w.hold  = H_MOD;
            U_WRITE: w.st_op = ST_WRITE;
            U_READ:  w.st_op = ST_READ;
            U_BLL0:
            begin
                w.acc_op = ACC_LOAD; w.a_sel = A_DL; w.b_sel = B_NR;
            end
            U_BLL1:
            begin
                w.acc_op = ACC_ADD;  w.a_sel = A_XL; w.b_sel = B_R;
            end
            U_BLR0:
            begin
                w.rnd_dst = R_T0;
                w.acc_op = ACC_LOAD; w.a_sel = A_DR; w.b_sel = B_NR;
            end
            U_BLR1:
            begin
                w.acc_op = ACC_ADD;  w.a_sel = A_XR; w.b_sel = B_R;
            end
            U_WGL:
            begin
                w.rnd_dst = R_T1;
                w.acc_op = ACC_LOAD; w.a_sel = A_T0; w.b_sel = B_WG;
            end
            U_WGR:
            begin
                w.rnd_dst = R_T0;
                w.acc_op = ACC_LOAD; w.a_sel = A_T1; w.b_sel = B_WG;
            end
            U_WGE:   w.rnd_dst = R_T1;
            U_MID0:
            begin
                w.acc_op = ACC_LOAD; w.a_sel = A_SUM; w.b_sel = B_ONE;
            end
            U_MID1:
            begin
                w.acc_op = ACC_ADD;  w.a_sel = A_DIF; w.b_sel = B_SW;
            end
            U_SIDE0:
            begin
                w.rnd_dst = R_T2; w.rnd17 = 1'b1;
                w.acc_op = ACC_LOAD; w.a_sel = A_SUM; w.b_sel = B_ONE;
            end
            U_SIDE1:
            begin
                w.acc_op = ACC_SUB;  w.a_sel = A_DIF; w.b_sel = B_SW;
            end
            U_MIXL:
            begin
                w.rnd_dst = R_T1; w.rnd17 = 1'b1;
                w.acc_op = ACC_LOAD; w.a_sel = A_T2; w.b_sel = B_MG;
            end
            U_MIXR:
            begin
                w.rnd_dst = R_OL;
                w.acc_op = ACC_LOAD; w.a_sel = A_T1; w.b_sel = B_MG;
            end
            U_MIXE:  w.rnd_dst = R_OR;
            U_EMIT:
            begin
                w.hold   = H_OUT;
                w.emit   = 1'b1;
                w.jmp    = 1'b1;
                w.target = U_IDLE;
            end
            default:
            begin
                w.jmp    = 1'b1;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/sdwm_regs.sv
`timescale 1ns / 1ps
module sdwm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdwm_pkg::ADDR_W-1:0] paddr,
    input  logic [sdwm_pkg::DATA_W-1:0] pwdata,
    output logic [sdwm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output sdwm_pkg::sdwm_cfg_t         cfg
);
    import sdwm_pkg::*;

    sdwm_cfg_t        cfg_reg;
    sdwm_cfg_t        cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] rval;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign wval   = pwdata[CFG_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DELAY: cfg_next.delay = wval;
                REG_BLEND: cfg_next.blend = wval;
                REG_WET:   cfg_next.wet   = wval;
                REG_WIDTH: cfg_next.width = wval;
                REG_MIX:   cfg_next.mix   = wval;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay <= DELAY_RST;
            cfg_reg.blend <= BLEND_RST;
            cfg_reg.wet   <= WET_RST;
            cfg_reg.width <= WIDTH_RST;
            cfg_reg.mix   <= MIX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DELAY: rval = cfg_reg.delay;
            REG_BLEND: rval = cfg_reg.blend;
            REG_WET:   rval = cfg_reg.wet;
            REG_WIDTH: rval = cfg_reg.width;
            REG_MIX:   rval = cfg_reg.mix;
            default:   rval = '0;
        endcase
    end

    assign prdata = {{(DATA_W-CFG_W){1'b0}}, rval};
    assign cfg    = cfg_reg;

endmodule

// File: rtl/sdwm_seq.sv
`timescale 1ns / 1ps
module sdwm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdwm_pkg::sdwm_stat_t stat,
    output sdwm_pkg::sdwm_uc_t   uc,
    output logic                 fire
);
    import sdwm_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              hold;

    assign uc = ucode(step_reg);

    always_comb
    begin
        unique case (uc.hold)
            H_NONE: hold = 1'b0;
            H_IN:   hold = !stat.in_valid;
            H_MOD:  hold = !stat.mod_done;
            H_OUT:  hold = !stat.out_free;
        endcase
    end

    assign fire = !hold;

    always_comb
    begin
        priority if (hold)
            step_next = step_reg;
        else if (uc.jmp)
            step_next = uc.target;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= U_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// File: rtl/sdwm_store.sv
`timescale 1ns / 1ps
module sdwm_store #(
    parameter int DEPTH       = sdwm_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = sdwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sdwm_pkg::sdwm_uc_t           uc,
    input  logic                         fire,
    input  logic [sdwm_pkg::CFG_W-1:0]   delay,
    input  logic [SAMPLE_BITS-1:0]       wr_left,
    input  logic [SAMPLE_BITS-1:0]       wr_right,
    output logic [SAMPLE_BITS-1:0]       dly_left,
    output logic [SAMPLE_BITS-1:0]       dly_right,
    output logic                         mod_done
);
    import sdwm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int XW = ((FW > CFG_W) ? FW : CFG_W) + 1;
    localparam int RK = CFG_W + 1;
    localparam int PW = CFG_W + RK;
    localparam int MW = CFG_W + FW;
    localparam int EW = 2 * SAMPLE_BITS;

    // Reciprocal of the depth, rounded down, scaled by 2^RK
    localparam logic [RK-1:0] RECIP = RK'((longint'(1) << RK) / DEPTH);

    logic [EW-1:0]    mem [DEPTH];

    logic [CFG_W-1:0] off_reg,  off_next;
    logic [CFG_W-1:0] quo_reg,  quo_next;
    logic [1:0]       cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic [AW-1:0]    wp_reg,   wp_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    rd_reg,   rd_next;
    logic             hit_reg,  hit_next;
    logic             rvalid_reg, rvalid_next;
    logic [EW-1:0]    rdata_reg;

    logic             do_mod;
    logic             do_wr;
    logic             do_rd;
    logic [XW-1:0]    wp_x;
    logic [XW-1:0]    off_x;
    logic [XW-1:0]    rd_x;
    logic [XW-1:0]    red_x;
    logic [PW-1:0]    quo_prod;
    logic [MW-1:0]    sub_x;

    assign do_mod = fire && (uc.st_op == ST_MOD);
    assign do_wr  = fire && (uc.st_op == ST_WRITE);
    assign do_rd  = fire && (uc.st_op == ST_READ);

    assign wp_x  = XW'(wp_reg);
    assign off_x = XW'(off_reg);
    assign rd_x  = (wp_x >= off_x) ? (wp_x - off_x) : (wp_x + XW'(DEPTH) - off_x);

    assign quo_prod = PW'(off_reg) * PW'(RECIP);
    assign sub_x    = MW'(quo_reg) * MW'(DEPTH);
    assign red_x    = off_x - XW'(DEPTH);

    always_comb
    begin
        off_next    = off_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        rd_next     = rd_reg;
        hit_next    = hit_reg;
        rvalid_next = rvalid_reg;

        // Reduce the delay below the depth: estimate the quotient, subtract
        // its multiple of the depth, then correct by one depth at most
        if (do_mod)
        begin
            off_next  = delay;
            cnt_next  = 2'd3;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            priority if (cnt_reg == 2'd3)
                quo_next = quo_prod[PW-1:RK];
            else if (cnt_reg == 2'd2)
                off_next = off_reg - sub_x[CFG_W-1:0];
            else
            begin
                if (off_x >= XW'(DEPTH))
                    off_next = red_x[CFG_W-1:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != 2'd1);
        end

        if (do_wr)
        begin
            wp_next   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            fill_next = (fill_reg == FW'(DEPTH)) ? fill_reg : fill_reg + 1'b1;
            rd_next   = rd_x[AW-1:0];
            // An entry never written since reset reads as zero
            hit_next  = off_x < XW'(fill_next);
        end

        if (do_rd)
            rvalid_next = hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            quo_reg    <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            rd_reg     <= '0;
            hit_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            off_reg    <= off_next;
            quo_reg    <= quo_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            rd_reg     <= rd_next;
            hit_reg    <= hit_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= {wr_right, wr_left};
        if (do_rd)
            rdata_reg <= mem[rd_reg];
    end

    assign dly_left  = rvalid_reg ? rdata_reg[SAMPLE_BITS-1:0] : '0;
    assign dly_right = rvalid_reg ? rdata_reg[EW-1:SAMPLE_BITS] : '0;
    assign mod_done  = !busy_reg;

endmodule

// File: rtl/sdwm_dp.sv
`timescale 1ns / 1ps
module sdwm_dp #(
    parameter int SAMPLE_BITS = sdwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdwm_pkg::sdwm_uc_t     uc,
    input  logic                   fire,
    input  sdwm_pkg::sdwm_cfg_t    cfg,
    input  logic [SAMPLE_BITS-1:0] left_in,
    input  logic [SAMPLE_BITS-1:0] right_in,
    input  logic                   block_last,
    input  logic [SAMPLE_BITS-1:0] dly_left,
    input  logic [SAMPLE_BITS-1:0] dly_right,
    output logic [SAMPLE_BITS-1:0] x_left,
    output logic [SAMPLE_BITS-1:0] x_right,
    output logic [SAMPLE_BITS-1:0] left_out,
    output logic [SAMPLE_BITS-1:0] right_out,
    output logic                   block_end,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import sdwm_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int TW   = S + 1;
    localparam int OW   = S + 2;
    localparam int BW   = CFG_W + 1;
    localparam int PW   = OW + BW;
    localparam int ACCW = PW + 1;

    localparam logic signed [ACCW-1:0] HALF16 = ACCW'(32768);
    localparam logic signed [ACCW-1:0] HALF17 = ACCW'(65536);

    logic        [S-1:0]    xl_reg, xr_reg;
    logic                   last_reg;
    logic signed [TW-1:0]   t0_reg, t0_next;
    logic signed [TW-1:0]   t1_reg, t1_next;
    logic signed [TW-1:0]   t2_reg, t2_next;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic        [S-1:0]    ol_reg, ol_next;
    logic        [S-1:0]    or_reg, or_next;
    logic        [S-1:0]    lo_reg, ro_reg;
    logic                   end_reg;
    logic                   vld_reg, vld_next;

    logic [CFG_W-1:0]       r_c, wg_c, sw_c, mg_c;
    logic signed [OW-1:0]   a_op;
    logic signed [BW-1:0]   b_op;
    logic signed [PW-1:0]   prod;
    logic signed [ACCW-1:0] prod_x;
    logic signed [ACCW-1:0] acc_rnd;
    logic signed [ACCW-1:0] acc_sh;
    logic signed [TW-1:0]   rnd_val;
    logic        [S-1:0]    sat_l, sat_r;
    logic                   emit_now;

    // Gains above unity act as unity
    assign r_c  = (cfg.blend > GAIN_ONE) ? GAIN_ONE : cfg.blend;
    assign wg_c = (cfg.wet   > GAIN_ONE) ? GAIN_ONE : cfg.wet;
    assign sw_c = (cfg.width > GAIN_ONE) ? GAIN_ONE : cfg.width;
    assign mg_c = (cfg.mix   > GAIN_ONE) ? GAIN_ONE : cfg.mix;

    always_comb
    begin
        unique case (uc.a_sel)
            A_XL:    a_op = {{2{xl_reg[S-1]}}, xl_reg};
            A_XR:    a_op = {{2{xr_reg[S-1]}}, xr_reg};
            A_DL:    a_op = {{2{dly_left[S-1]}}, dly_left};
            A_DR:    a_op = {{2{dly_right[S-1]}}, dly_right};
            A_T0:    a_op = {t0_reg[TW-1], t0_reg};
            A_T1:    a_op = {t1_reg[TW-1], t1_reg};
            A_T2:    a_op = {t2_reg[TW-1], t2_reg};
            A_SUM:   a_op = {t0_reg[TW-1], t0_reg} + {t1_reg[TW-1], t1_reg};
            A_DIF:   a_op = {t0_reg[TW-1], t0_reg} - {t1_reg[TW-1], t1_reg};
            default: a_op = '0;
        endcase
    end

    always_comb
    begin
        unique case (uc.b_sel)
            B_R:     b_op = {1'b0, r_c};
            B_NR:    b_op = {1'b0, GAIN_ONE - r_c};
            B_WG:    b_op = {1'b0, wg_c};
            B_ONE:   b_op = {1'b0, GAIN_ONE};
            B_SW:    b_op = {1'b0, sw_c};
            B_MG:    b_op = {1'b0, mg_c};
            default: b_op = '0;
        endcase
    end

    assign prod   = a_op * b_op;
    assign prod_x = {prod[PW-1], prod};

    // Round half up: add half an LSB, then floor
    assign acc_rnd = acc_reg + (uc.rnd17 ? HALF17 : HALF16);
    assign acc_sh  = uc.rnd17 ? (acc_rnd >>> 17) : (acc_rnd >>> 16);
    assign rnd_val = acc_sh[TW-1:0];

    function automatic logic [S-1:0] sat_add(input logic [S-1:0] x,
                                             input logic [TW-1:0] v);
        logic [S+1:0] s;
        logic [S-1:0] r;
        s = {{2{x[S-1]}}, x} + {v[TW-1], v};
        if ((s[S+1:S-1] == 3'b000) || (s[S+1:S-1] == 3'b111))
            r = s[S-1:0];
        else if (s[S+1])
            r = {1'b1, {(S-1){1'b0}}};
        else
            r = {1'b0, {(S-1){1'b1}}};
        return r;
    endfunction

    assign sat_l = sat_add(xl_reg, rnd_val);
    assign sat_r = sat_add(xr_reg, rnd_val);

    always_comb
    begin
        acc_next = acc_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        t2_next  = t2_reg;
        ol_next  = ol_reg;
        or_next  = or_reg;
        if (fire)
        begin
            unique case (uc.acc_op)
                ACC_HOLD: acc_next = acc_reg;
                ACC_LOAD: acc_next = prod_x;
                ACC_ADD:  acc_next = acc_reg + prod_x;
                ACC_SUB:  acc_next = acc_reg - prod_x;
            endcase
            unique case (uc.rnd_dst)
                R_T0:    t0_next = rnd_val;
                R_T1:    t1_next = rnd_val;
                R_T2:    t2_next = rnd_val;
                R_OL:    ol_next = sat_l;
                R_OR:    or_next = sat_r;
                default: t0_next = t0_reg;
            endcase
        end
    end

    assign emit_now = fire && uc.emit;

    always_comb
    begin
        priority if (emit_now)
            vld_next = 1'b1;
        else if (out_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        ol_reg  <= ol_next;
        or_reg  <= or_next;
        if (fire && uc.take)
        begin
            xl_reg   <= left_in;
            xr_reg   <= right_in;
            last_reg <= block_last;
        end
        if (emit_now)
        begin
            lo_reg  <= ol_reg;
            ro_reg  <= or_reg;
            end_reg <= last_reg;
        end
    end

    assign x_left    = xl_reg;
    assign x_right   = xr_reg;
    assign left_out  = lo_reg;
    assign right_out = ro_reg;
    assign block_end = end_reg;
    assign out_valid = vld_reg;

endmodule

// File: rtl/stereo_delay_width_mix.sv
`timescale 1ns / 1ps
// Stereo delay with blend, wet gain, mid/side width and dry/wet sum. One
// stereo frame enters on the slave stream and one processed frame leaves on
// the master stream, with tlast carried along. The next frame is taken in
// the cycle after the result is handed to the output register, so a new
// frame can be accepted while an earlier result still waits. Each frame
// goes through reducing delay_samples modulo DEPTH (a reciprocal multiply,
// a multiply-subtract and one correcting subtraction), the delay store
// write and read, the shared multiply-accumulate unit (one product per
// cycle) and handshake steps of the control program. The delay store
// needs no clearing pass after reset: a fill count makes frames not yet
// written read as silence. Configuration must be written over the APB port
// only while no frame is in flight; the block itself does not enforce this.
module stereo_delay_width_mix #(
    parameter int DEPTH       = sdwm_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = sdwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Slave stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // left_in, right_in (low to high), zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,   // block_last
    // Master stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // left_out, right_out (low to high), zero padded to bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                        m_axis_tlast,   // block_end
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdwm_pkg::ADDR_W-1:0] paddr,
    input  logic [sdwm_pkg::DATA_W-1:0] pwdata,
    output logic [sdwm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import sdwm_pkg::*;

    localparam int S = SAMPLE_BITS;

    sdwm_cfg_t  cfg;
    sdwm_uc_t   uc;
    sdwm_stat_t stat;
    logic       fire;
    logic       mod_done;

    logic [S-1:0] x_left, x_right;
    logic [S-1:0] dly_left, dly_right;
    logic [S-1:0] left_out, right_out;

    // Register file
    sdwm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Status seen by the step sequencer: hold in idle until an item is
    // offered, hold while the delay is reduced, hold the final step until
    // the output register is free.
    assign stat.in_valid = s_axis_tvalid;
    assign stat.mod_done = mod_done;
    assign stat.out_free = !m_axis_tvalid || m_axis_tready;

    sdwm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uc    (uc),
        .fire  (fire)
    );

    // Accept only in the idle step of the program
    assign s_axis_tready = uc.take;

    // Delay store with pointer, fill count and modulo reduction
    sdwm_store #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .uc        (uc),
        .fire      (fire),
        .delay     (cfg.delay),
        .wr_left   (x_left),
        .wr_right  (x_right),
        .dly_left  (dly_left),
        .dly_right (dly_right),
        .mod_done  (mod_done)
    );

    // Multiply-accumulate datapath and output register
    sdwm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .uc         (uc),
        .fire       (fire),
        .cfg        (cfg),
        .left_in    (s_axis_tdata[S-1:0]),
        .right_in   (s_axis_tdata[2*S-1:S]),
        .block_last (s_axis_tlast),
        .dly_left   (dly_left),
        .dly_right  (dly_right),
        .x_left     (x_left),
        .x_right    (x_right),
        .left_out   (left_out),
        .right_out  (right_out),
        .block_end  (m_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    // Pack the result, pad bits stay zero
    always_comb
    begin
        m_axis_tdata          = '0;
        m_axis_tdata[S-1:0]   = left_out;
        m_axis_tdata[2*S-1:S] = right_out;
    end

    // One item in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // A result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire && uc.emit |-> !m_axis_tvalid || m_axis_tready)
        else $error("result overwrote a pending output");

    // The store write uses a fully reduced delay offset
    a_write_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (uc.st_op == ST_WRITE) |-> mod_done)
        else $error("store write before delay reduction finished");

    // An emitted result shows up on the output
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fire && uc.emit |=> m_axis_tvalid)
        else $error("emitted result not presented");

endmodule

// File: verif/stereo_delay_width_mix_checker.sv
`timescale 1ns / 1ps
module stereo_delay_width_mix_checker #(
    parameter int DEPTH       = sdwm_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = sdwm_pkg::SAMPLE_BITS_DEF,
    parameter int TDATA_W     = ((2*SAMPLE_BITS+7)/8)*8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // left_in, right_in (low to high), zero padded to bytes
    input  logic [TDATA_W-1:0]          s_axis_tdata,
    input  logic                        s_axis_tlast,   // block_last
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // left_out, right_out (low to high), zero padded to bytes
    input  logic [TDATA_W-1:0]          m_axis_tdata,
    input  logic                        m_axis_tlast,   // block_end
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdwm_pkg::ADDR_W-1:0] paddr,
    input  logic [sdwm_pkg::DATA_W-1:0] pwdata,
    input  logic [sdwm_pkg::DATA_W-1:0] prdata,
    input  logic                        pready,
    output int                          errors,
    output int                          pending
);
    import sdwm_pkg::*;

    localparam int SB = SAMPLE_BITS;

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic          last;
    } frame_t;

    logic [SB-1:0]    left_line  [DEPTH];
    logic [SB-1:0]    right_line [DEPTH];
    int unsigned      wr_ptr;
    sdwm_cfg_t        cfg;
    frame_t           frames_q[$];
    frame_t           want;
    logic [CFG_W-1:0] reg_word;
    logic             reg_known;
    int               fail_count;
    int               frame_no;

    // Add half an LSB, then floor.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Clamp gains above unity.
    function automatic longint gain_of(input logic [CFG_W-1:0] g);
        return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
    endfunction

    function automatic longint sext(input logic [SB-1:0] s);
        return {{(64-SB){s[SB-1]}}, s};
    endfunction

    function automatic logic [SB-1:0] clamp_sample(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SB - 1)) - 1;
        lo = -(longint'(1) <<< (SB - 1));
        if (v > hi)
            return hi[SB-1:0];
        if (v < lo)
            return lo[SB-1:0];
        return v[SB-1:0];
    endfunction

    // Write the frame into both delay lines, read the delayed pair back and
    // run blend, wet gain, width and dry/wet sum.
    function automatic frame_t delay_mix_frame(input logic [TDATA_W-1:0] data,
                                               input logic last);
        frame_t      f;
        int unsigned wp;
        int unsigned off;
        int unsigned rd;
        longint      unity;
        longint      xl, xr, dl, dr, r, wg, sw, mg;
        longint      bl, br, wet_l, wet_r, sum, dif, ml, mr;
        unity = longint'(GAIN_ONE);
        xl    = sext(data[SB-1:0]);
        xr    = sext(data[2*SB-1:SB]);
        wp    = wr_ptr % DEPTH;
        off   = int'(cfg.delay) % DEPTH;
        rd    = (wp + DEPTH - off) % DEPTH;
        r     = gain_of(cfg.blend);
        wg    = gain_of(cfg.wet);
        sw    = gain_of(cfg.width);
        mg    = gain_of(cfg.mix);

        left_line[wp]  = data[SB-1:0];
        right_line[wp] = data[2*SB-1:SB];
        wr_ptr = (wp + 1) % DEPTH;
        dl = sext(left_line[rd]);
        dr = sext(right_line[rd]);

        bl    = round_shift(dl * (unity - r) + xl * r, 16);
        br    = round_shift(dr * (unity - r) + xr * r, 16);
        wet_l = round_shift(bl * wg, 16);
        wet_r = round_shift(br * wg, 16);
        sum   = wet_l + wet_r;
        dif   = wet_l - wet_r;
        ml    = round_shift(sum * unity + dif * sw, 17);
        mr    = round_shift(sum * unity - dif * sw, 17);

        f.left  = clamp_sample(xl + round_shift(ml * mg, 16));
        f.right = clamp_sample(xr + round_shift(mr * mg, 16));
        f.last  = last;
        return f;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        $display("%0t: frame %0d %s: expected %0h, got %0h",
                 $time, frame_no, what, exp_val, got_val);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                left_line[i]  = '0;
                right_line[i] = '0;
            end
            wr_ptr     = 0;
            cfg        = '{DELAY_RST, BLEND_RST, WET_RST, WIDTH_RST, MIX_RST};
            frames_q.delete();
            fail_count = 0;
            frame_no   = 0;
            pending   <= 0;
            errors    <= 0;
        end
        else
        begin
            // Check results first: a frame taken at this edge cannot leave yet.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (frames_q.size() == 0)
                    report_mismatch("unexpected frame", '0, 64'(m_axis_tdata));
                else
                begin
                    want = frames_q.pop_front();
                    if (m_axis_tdata[SB-1:0] !== want.left)
                        report_mismatch("left_out", 64'(want.left),
                                        64'(m_axis_tdata[SB-1:0]));
                    if (m_axis_tdata[2*SB-1:SB] !== want.right)
                        report_mismatch("right_out", 64'(want.right),
                                        64'(m_axis_tdata[2*SB-1:SB]));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("block_end", 64'(want.last), 64'(m_axis_tlast));
                end
                frame_no++;
            end

            if (psel && penable && pready)
            begin
                reg_known = 1'b1;
                case (paddr[IDX_W+1:2])
                    REG_DELAY: reg_word = cfg.delay;
                    REG_BLEND: reg_word = cfg.blend;
                    REG_WET:   reg_word = cfg.wet;
                    REG_WIDTH: reg_word = cfg.width;
                    REG_MIX:   reg_word = cfg.mix;
                    default:
                    begin
                        reg_word  = '0;
                        reg_known = 1'b0;
                    end
                endcase
                if (pwrite)
                begin
                    case (paddr[IDX_W+1:2])
                        REG_DELAY: cfg.delay = pwdata[CFG_W-1:0];
                        REG_BLEND: cfg.blend = pwdata[CFG_W-1:0];
                        REG_WET:   cfg.wet   = pwdata[CFG_W-1:0];
                        REG_WIDTH: cfg.width = pwdata[CFG_W-1:0];
                        REG_MIX:   cfg.mix   = pwdata[CFG_W-1:0];
                        default: ;
                    endcase
                end
                else if (reg_known && prdata !== DATA_W'(reg_word))
                    report_mismatch("register readback", 64'(reg_word), 64'(prdata));
            end

            if (s_axis_tvalid && s_axis_tready)
                frames_q.push_back(delay_mix_frame(s_axis_tdata, s_axis_tlast));

            pending <= frames_q.size();
            errors  <= fail_count;
        end
    end

endmodule

// File: verif/stereo_delay_width_mix_tb.sv
`timescale 1ns / 1ps
// Top of the stereo delay testbench: clock, reset, stimulus and verdict.
// All prediction and comparison lives in the checker instantiated next to
// the block; this module only makes traffic and reads back its counts.
module stereo_delay_width_mix_tb;
    import sdwm_pkg::*;

    localparam int SB              = SAMPLE_BITS_DEF;
    localparam int TDATA_W         = ((2*SB+7)/8)*8;
    localparam int IDLE_LIMIT      = 30000;   // cycles without any handshake
    localparam int HOLD_OFF_CYCLES = 3000;    // long receiver stall
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 78;
    localparam int PRESSURE_PHASE  = 3;
    localparam int TAIL_CYCLES     = 40;      // longer than one frame of latency

    localparam logic [SB-1:0]    SMAX      = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0]    SMIN      = {1'b1, {(SB-1){1'b0}}};
    localparam logic [CFG_W-1:0] GAIN_OVER = {CFG_W{1'b1}};
    localparam logic [CFG_W-1:0] DELAY_MAX = {CFG_W{1'b1}};

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tready = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [DATA_W-1:0]   pwdata        = '0;

    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  errors;
    int                  pending;

    // Traffic shaping shared between the sender, the receiver and the
    // sequence: steady means no gaps on that side for the current phase.
    bit                  tx_steady     = 1'b0;
    bit                  rx_steady     = 1'b0;
    bit                  hold_off_req  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stereo_delay_width_mix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    stereo_delay_width_mix_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 40);
        return $urandom_range(41, 300);
    endfunction

    // Full-range samples with extra weight on the rails and near zero.
    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SMAX;
            1:       return SMIN;
            2:       return SB'($urandom_range(0, 255));
            3:       return -SB'($urandom_range(1, 256));
            default: return SB'($urandom());
        endcase
    endfunction

    // Gains: zero, unity, above unity (clamped by the block) or anything between.
    function automatic logic [CFG_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GAIN_ONE;
            2:       return CFG_W'($urandom_range(GAIN_ONE + 1, GAIN_OVER));
            3:       return GAIN_OVER;
            default: return CFG_W'($urandom_range(0, GAIN_ONE));
        endcase
    endfunction

    // Mostly short delays so the delayed reads hit frames sent in the phase.
    function automatic sdwm_cfg_t rand_config();
        sdwm_cfg_t c;
        case ($urandom_range(0, 7))
            0:       c.delay = '0;
            1:       c.delay = CFG_W'(1);
            2:       c.delay = DELAY_MAX;
            3:       c.delay = CFG_W'($urandom());
            default: c.delay = CFG_W'($urandom_range(0, 48));
        endcase
        c.blend = rand_gain();
        c.wet   = rand_gain();
        c.width = rand_gain();
        c.mix   = rand_gain();
        return c;
    endfunction

    // Offer one frame after an optional gap and hold it until taken.
    // Keep tvalid high across back-to-back frames.
    task automatic send_frame(input logic [SB-1:0] left, input logic [SB-1:0] right,
                              input logic last);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({right, left});
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop tvalid and wait until every predicted frame has come out. The
    // first edge lets the checker count a frame taken at the last edge.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One APB transfer: setup cycle, access cycle, then an idle cycle so
    // that back-to-back transfers never reassign psel in the same step.
    task automatic apb_xfer(input logic wr, input logic [IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        if ($urandom_range(0, 1))
            junk = '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[DATA_W-1:CFG_W], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Read every register back; the checker compares against its copy.
    task automatic read_all();
        for (int i = REG_DELAY; i <= REG_MIX; i++)
            apb_xfer(1'b0, IDX_W'(i), '0);
    endtask

    task automatic set_config(input sdwm_cfg_t c);
        apb_xfer(1'b1, REG_DELAY, c.delay);
        apb_xfer(1'b1, REG_BLEND, c.blend);
        apb_xfer(1'b1, REG_WET,   c.wet);
        apb_xfer(1'b1, REG_WIDTH, c.width);
        apb_xfer(1'b1, REG_MIX,   c.mix);
        read_all();
    endtask

    // Receiver: random tready with gaps, steady stretches, and one long
    // hold-off on request so the block backs up and stalls its input.
    initial
    begin : sink
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (rx_steady)
                m_axis_tready <= 1'b1;
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 5)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : sequence_main
        sdwm_cfg_t c;
        // Hold reset, then release it once for good.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: read back, then a few frames against the default
        // delay, which reaches only never-written (silent) slots.
        read_all();
        send_frame(SMAX, SMIN, 1'b1);
        send_frame(SMIN, SMAX, 1'b0);
        send_frame('0, '0, 1'b1);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        wait_drained();

        // Zero delay, every gain at unity: the read returns the frame just
        // written and the sum drives the output into saturation.
        c = '{'0, GAIN_ONE, GAIN_ONE, GAIN_ONE, GAIN_ONE};
        set_config(c);
        send_frame(SMAX, SMAX, 1'b0);
        send_frame(SMIN, SMIN, 1'b1);
        send_frame(SMAX, SMIN, 1'b0);
        send_frame(SMIN, SMAX, 1'b1);
        send_frame(24'h555555, 24'hAAAAAA, 1'b0);
        send_frame(24'hAAAAAA, 24'h555555, 1'b1);
        wait_drained();

        // One-frame delay with every gain register above unity.
        c = '{CFG_W'(1), GAIN_OVER, GAIN_OVER, GAIN_OVER, GAIN_OVER};
        set_config(c);
        send_frame(SMAX, SMIN, 1'b0);
        send_frame(SMIN, SMAX, 1'b0);
        send_frame(rand_sample(), rand_sample(), 1'b1);
        send_frame(SMAX, SMAX, 1'b0);
        send_frame(rand_sample(), rand_sample(), 1'b1);
        wait_drained();

        // Longest delay, all gains zero: output is the dry input.
        c = '{DELAY_MAX, '0, '0, '0, '0};
        set_config(c);
        send_frame(SMAX, SMIN, 1'b1);
        send_frame(SMIN, SMAX, 1'b0);
        send_frame('0, SMAX, 1'b1);
        send_frame(rand_sample(), rand_sample(), 1'b0);
        wait_drained();

        // Writes past the last register must leave everything unchanged.
        for (int i = REG_MIX + 1; i < (1 << IDX_W); i++)
            apb_xfer(1'b1, IDX_W'(i), CFG_W'($urandom()));
        read_all();

        // Random phases: new settings each time, random content, and
        // steady or gappy traffic on each side chosen per phase.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(rand_config());
            tx_steady = ($urandom_range(0, 3) == 0) || (p == PRESSURE_PHASE);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Stall the receiver for a long stretch while frames keep coming.
                if (p == PRESSURE_PHASE && k == 10)
                    hold_off_req = 1'b1;
                send_frame(rand_sample(), rand_sample(), $urandom_range(0, 3) == 0);
            end
            wait_drained();
        end

        rx_steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sdwm_pkg.sv
rtl/sdwm_regs.sv
rtl/sdwm_seq.sv
rtl/sdwm_store.sv
rtl/sdwm_dp.sv
rtl/stereo_delay_width_mix.sv
verif/stereo_delay_width_mix_checker.sv
verif/stereo_delay_width_mix_tb.sv
